// ----- hw/rtl/dnle_pkg.sv -----
// Shared constants and controller/datapath interface types for the DNS name label encoder.
`default_nettype none

package dnle_pkg;

	localparam int unsigned LABEL_MAX = 63;
	localparam int unsigned CNT_W     = 6;
	localparam int unsigned BYTE_W    = 8;

	localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
	localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(LABEL_MAX);

	typedef struct packed {
		logic accept;
		logic load_len;
		logic issue_rd;
		logic load_byte;
	} cmd_t;

	typedef struct packed {
		logic is_dot;
		logic cnt_zero;
		logic idx_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dnle_ctrl.sv -----
// Controller state machine that sequences request intake and label emission.
`default_nettype none

module dnle_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_tvalid,
	input  wire             s_tlast,
	output logic            s_tready,
	input  wire dnle_pkg::sts_t sts,
	output dnle_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEN,
		ST_RD,
		ST_BYTE
	} state_t;

	state_t state_q;

	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		cmd           = '0;
		cmd.accept    = (state_q == ST_IDLE) && s_tvalid;
		cmd.load_len  = (state_q == ST_LEN) && sts.out_free;
		cmd.issue_rd  = (state_q == ST_RD);
		cmd.load_byte = (state_q == ST_BYTE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && (sts.is_dot || s_tlast)) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (sts.out_free) begin
						state_q <= sts.cnt_zero ? ST_IDLE : ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_BYTE;
				end
				ST_BYTE: begin
					if (sts.out_free) begin
						state_q <= sts.idx_last ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dnle_datapath.sv -----
// Datapath: label store, counters, read register and output register.
`default_nettype none

module dnle_datapath (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [dnle_pkg::BYTE_W-1:0]    character,
	input  wire                            final_char,
	input  wire dnle_pkg::cmd_t            cmd,
	output dnle_pkg::sts_t                 sts,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [dnle_pkg::BYTE_W-1:0]    out_byte,
	output logic                           run_last,
	output logic                           name_done,
	output logic                           label_overflow
);

	logic [dnle_pkg::BYTE_W-1:0] mem [dnle_pkg::LABEL_MAX];

	logic [dnle_pkg::CNT_W-1:0]  cnt_q;
	logic [dnle_pkg::CNT_W-1:0]  idx_q;
	logic [dnle_pkg::CNT_W-1:0]  idx_nxt;
	logic                        ovf_q;
	logic                        fin_q;
	logic [dnle_pkg::BYTE_W-1:0] rd_q;
	logic                        valid_q;
	logic [dnle_pkg::BYTE_W-1:0] byte_q;
	logic                        last_q;
	logic                        done_q;
	logic                        oflag_q;
	logic                        is_dot;
	logic                        idx_last;

	assign is_dot   = (character == dnle_pkg::DOT_CHAR);
	assign idx_nxt  = dnle_pkg::CNT_W'(idx_q + 1'b1);
	assign idx_last = (idx_nxt == cnt_q);

	assign sts.is_dot   = is_dot;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.idx_last = idx_last;
	assign sts.out_free = !valid_q || out_ready;

	assign out_valid      = valid_q;
	assign out_byte       = byte_q;
	assign run_last       = last_q;
	assign name_done      = done_q;
	assign label_overflow = oflag_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && !is_dot && (cnt_q < dnle_pkg::CNT_LIMIT)) begin
			mem[cnt_q] <= character;
		end
		if (cmd.issue_rd) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
			fin_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				fin_q <= final_char;
				if (!is_dot) begin
					if (cnt_q < dnle_pkg::CNT_LIMIT) begin
						cnt_q <= dnle_pkg::CNT_W'(cnt_q + 1'b1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
			if (cmd.load_len) begin
				valid_q <= 1'b1;
				idx_q   <= '0;
				if (cnt_q == '0) begin
					ovf_q <= 1'b0;
				end
			end else if (cmd.load_byte) begin
				valid_q <= 1'b1;
				idx_q   <= idx_nxt;
				if (idx_last) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_len) begin
			byte_q  <= dnle_pkg::BYTE_W'(cnt_q);
			last_q  <= (cnt_q == '0);
			done_q  <= fin_q && (cnt_q == '0);
			oflag_q <= ovf_q;
		end else if (cmd.load_byte) begin
			byte_q  <= rd_q;
			last_q  <= idx_last;
			done_q  <= fin_q && idx_last;
			oflag_q <= ovf_q;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dnle_pkg::CNT_LIMIT)
		else $error("label count above limit");

	a_idx_in_label: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_byte |-> (idx_q < cnt_q))
		else $error("label read beyond stored bytes");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_len || cmd.load_byte) |-> (!valid_q || out_ready))
		else $error("output register overwritten while held");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !(cmd.load_len || cmd.load_byte || cmd.issue_rd))
		else $error("request taken during emission");

endmodule

`default_nettype wire

// ----- hw/rtl/dns_name_label_encoder.sv -----
// Top level of the DNS name label encoder: controller plus datapath.
//
// channel  dir  handshake          tdata          tlast       tuser
// s_*      in   s_tvalid/s_tready  character      final_char  -
// m_*      out  m_tvalid/m_tready  out_byte       name_done   [0] run_last, [1] label_overflow
//
// A character request that ends no label is stored and leaves the encoder ready for the next request.
// A dot or final character starts an emission: the length byte is loaded first, then
// each label byte takes a registered read of the label memory and an output load.
// No request is taken during an emission; the output register holds a result until taken.
// Reset (arst_n low) clears the label count, overflow flag and output valid.
`default_nettype none

module dns_name_label_encoder (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] character
	input  wire        s_tlast,
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	output logic [1:0] m_tuser    // [0] run_last, [1] label_overflow
);

	dnle_pkg::cmd_t cmd;
	dnle_pkg::sts_t sts;

	dnle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dnle_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.character      (s_tdata),
		.final_char     (s_tlast),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_byte       (m_tdata),
		.run_last       (m_tuser[0]),
		.name_done      (m_tlast),
		.label_overflow (m_tuser[1])
	);

endmodule

`default_nettype wire

// ----- bench/dnle_encode_checker.sv -----
// Checker for the DNS name label encoder: predicts encoded bytes from accepted requests and compares.
`timescale 1ns / 1ps

module dnle_encode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] character
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic       m_tlast,
	input  logic [1:0] m_tuser,   // [0] run_last, [1] label_overflow
	output int         fails,
	output int         pending,
	output int         bytes_checked,
	output int         overflow_labels
);

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       name_done;
		logic       label_overflow;
	} enc_byte_t;

	enc_byte_t  expected_bytes [$];
	logic [7:0] label_store [dnle_pkg::LABEL_MAX];
	int         stored;
	logic       dropped;

	task automatic flush_label(input logic done);
		enc_byte_t b;
		b.out_byte       = 8'(stored);
		b.run_last       = (stored == 0);
		b.name_done      = done && (stored == 0);
		b.label_overflow = dropped;
		expected_bytes.push_back(b);
		for (int i = 0; i < stored; i++) begin
			b.out_byte  = label_store[i];
			b.run_last  = (i == stored - 1);
			b.name_done = done && (i == stored - 1);
			expected_bytes.push_back(b);
		end
		if (dropped)
			overflow_labels++;
		stored  = 0;
		dropped = 1'b0;
	endtask

	task automatic encode_char(input logic [7:0] ch, input logic fin);
		if (ch == dnle_pkg::DOT_CHAR) begin
			flush_label(fin);
		end else begin
			if (stored < dnle_pkg::LABEL_MAX) begin
				label_store[stored] = ch;
				stored++;
			end else begin
				dropped = 1'b1;
			end
			if (fin)
				flush_label(1'b1);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : watch
		enc_byte_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			stored          = 0;
			dropped         = 1'b0;
			fails           = 0;
			bytes_checked   = 0;
			overflow_labels = 0;
		end else begin
			if (s_tvalid && s_tready)
				encode_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected encoded byte %0h with no request pending", m_tdata);
					fails++;
				end else begin
					want = expected_bytes.pop_front();
					check_field("out_byte", want.out_byte, m_tdata);
					check_field("run_last", 8'(want.run_last), 8'(m_tuser[0]));
					check_field("name_done", 8'(want.name_done), 8'(m_tlast));
					check_field("label_overflow", 8'(want.label_overflow), 8'(m_tuser[1]));
					bytes_checked++;
				end
			end
		end
		pending = expected_bytes.size();
	end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the DNS name label encoder: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int HOLD_FROM  = 300;
	localparam int HOLD_LEN   = 260;
	localparam int CALM_FROM  = 700;
	localparam int CALM_UNTIL = 1000;
	localparam int RANDOM_CHARS = 350;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] character
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] out_byte
	logic       m_tlast;
	logic [1:0] m_tuser;   // [0] run_last, [1] label_overflow

	int   fails;
	int   pending;
	int   bytes_checked;
	int   overflow_labels;
	int   chars_sent;
	int   big_left;
	logic sender_calm;

	dns_name_label_encoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	dnle_encode_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.m_tuser         (m_tuser),
		.fails           (fails),
		.pending         (pending),
		.bytes_checked   (bytes_checked),
		.overflow_labels (overflow_labels)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_char(input logic [7:0] ch, input logic fin);
		while (!sender_calm && $urandom_range(99) < 13) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic drain_all();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send_name();
		int   labels;
		int   len;
		int   r;
		logic trail;
		logic [7:0] ch;
		labels = $urandom_range(1, 4);
		trail  = ($urandom_range(99) < 20);
		for (int k = 0; k < labels; k++) begin
			r = $urandom_range(99);
			if (r < 3 && big_left > 0) begin
				len = $urandom_range(62, 70);
				big_left--;
			end else if (r < 12) begin
				len = 0;
			end else begin
				len = $urandom_range(1, 12);
			end
			if (k == labels - 1 && len == 0)
				trail = 1'b1;
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(99) < 70)
					ch = 8'($urandom_range(8'h61, 8'h7A));
				else
					ch = 8'($urandom_range(0, 255));
				if (ch == dnle_pkg::DOT_CHAR)
					ch = 8'h2D;
				send_char(ch, (k == labels - 1) && !trail && (j == len - 1));
			end
			if (k < labels - 1)
				send_char(dnle_pkg::DOT_CHAR, 1'b0);
			else if (trail)
				send_char(dnle_pkg::DOT_CHAR, 1'b1);
		end
	endtask

	// receiver: random stalls, one long hold-off, one calm window
	initial begin : drain
		int cyc;
		cyc = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= HOLD_FROM && cyc < HOLD_FROM + HOLD_LEN)
				m_tready <= 1'b0;
			else if (cyc >= CALM_FROM && cyc < CALM_UNTIL)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= 13);
		end
	end

	initial begin : stimulus
		logic [8:0] directed [18];
		logic paused;
		int   n;
		directed = '{
			{1'b0, dnle_pkg::DOT_CHAR},
			{1'b0, 8'h61}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, dnle_pkg::DOT_CHAR},
			{1'b0, dnle_pkg::DOT_CHAR},
			{1'b1, 8'h7A},
			{1'b1, dnle_pkg::DOT_CHAR},
			{1'b0, 8'h41}, {1'b0, 8'h7F}, {1'b0, 8'h80}, {1'b1, dnle_pkg::DOT_CHAR},
			{1'b0, dnle_pkg::DOT_CHAR}, {1'b1, dnle_pkg::DOT_CHAR},
			{1'b0, 8'h55}, {1'b0, 8'hAA}, {1'b1, 8'h00},
			{1'b1, 8'h01}
		};
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = 8'h00;
		s_tlast     = 1'b0;
		sender_calm = 1'b0;
		chars_sent  = 0;
		big_left    = 4;
		paused      = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_char(directed[i][7:0], directed[i][8]);
		drain_all();

		n = chars_sent;
		while (chars_sent - n < RANDOM_CHARS) begin
			sender_calm = (chars_sent - n >= 250 && chars_sent - n < 310);
			if (!paused && chars_sent - n >= 200) begin
				drain_all();
				paused = 1'b1;
			end
			if ($urandom_range(99) < 12) begin
				repeat ($urandom_range(1, 6))
					send_char(8'($urandom_range(0, 255)), $urandom_range(99) < 30);
			end else begin
				send_name();
			end
		end

		drain_all();
		repeat (20) @(negedge clk);
		$display("Sent %0d name characters and checked %0d encoded bytes.",
			chars_sent, bytes_checked);
		$display("Labels that overflowed and dropped characters: %0d.", overflow_labels);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/dnle_pkg.sv
hw/rtl/dnle_ctrl.sv
hw/rtl/dnle_datapath.sv
hw/rtl/dns_name_label_encoder.sv
bench/dnle_encode_checker.sv
bench/tb_top.sv
